// ===== rtl/fsq_pkg.sv =====
// ---------------------------------------------------------------------------
// fsq_pkg: shared types and constants of the fixed-point square root
// Result width, default word sizes and the control word that travels
// down the root chain beside each item.
// ---------------------------------------------------------------------------
package fsq_pkg;

  // Width of the root field on the result stream.
  localparam int unsigned ROOT_BITS = 24;

  // Default word size and fraction size (16.16).
  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Half of the normalizing shift; covers words up to 64 bits.
  localparam int unsigned SHALF_BITS = 5;

  // How the result of an item is formed at the end of the chain.
  typedef enum logic [1:0] {
    KIND_ROOT,   // take the computed root, shifted back
    KIND_ZERO,   // zero or negative radicand
    KIND_ONE     // radicand close to one
  } fsq_kind_e;

  typedef struct packed {
    fsq_kind_e                kind;
    logic [SHALF_BITS-1:0]    shift_half;
  } fsq_ctrl_t;

endpackage

// ===== rtl/fixed_sqrt_16_16_top.sv =====
// ---------------------------------------------------------------------------
// fixed_sqrt_16_16_top: square root of a signed 16.16 fixed-point value
// Streams radicands in and roots out through a chain of digit cells.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: one signed radicand per request in tdata.
//   Output stream m_axis: one unsigned root per request in tdata, in the
//   same order as the radicands. Zero or negative input yields 0; input
//   within 2^(FRAC_BITS/2-1) of one yields exactly one.
//   Each radicand passes through the normalize register, one cell per root
//   bit (ITERS = (WORD_BITS-2)/2 + 1 cells) and the scale-back register
//   before its root appears on m_axis.
//   Throughput: one request per cycle while m_axis_tready is high; every
//   cell holds its own item, so up to ITERS + 2 requests are in flight.
//   Reset clears all valid flags; the chain comes up empty and ready.
//   When the receiver stalls, results pile up cell by cell from the output
//   backwards; s_axis_tready drops only once every cell is occupied.
// ---------------------------------------------------------------------------
module fixed_sqrt_16_16_top #(
  parameter int unsigned WORD_BITS = fsq_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = fsq_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((WORD_BITS+7)/8)*8-1:0]       s_axis_tdata,  // radicand
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [fsq_pkg::ROOT_BITS-1:0]        m_axis_tdata   // root
);

  localparam int unsigned ITERS = ((WORD_BITS - 2) >> 1) + 1;
  localparam int unsigned CNTW  = $clog2(ITERS + 3);

  logic [ITERS:0]       cell_valid;
  logic [ITERS:0]       cell_ready;
  logic [WORD_BITS-1:0] cell_rem  [ITERS+1];
  logic [WORD_BITS-1:0] cell_z    [ITERS+1];
  fsq_pkg::fsq_ctrl_t   cell_ctrl [ITERS+1];

  fsq_norm #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_norm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s_axis_tvalid),
    .ready_o    (s_axis_tready),
    .radicand_i (s_axis_tdata[WORD_BITS-1:0]),
    .valid_o    (cell_valid[0]),
    .ready_i    (cell_ready[0]),
    .rem_o      (cell_rem[0]),
    .ctrl_o     (cell_ctrl[0])
  );

  assign cell_z[0] = '0;

  for (genvar k = 0; k < ITERS; k++) begin : g_cell
    fsq_cell #(
      .WORD_BITS (WORD_BITS),
      .ITERS     (ITERS),
      .STEP      (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cell_valid[k]),
      .ready_o (cell_ready[k]),
      .rem_i   (cell_rem[k]),
      .z_i     (cell_z[k]),
      .ctrl_i  (cell_ctrl[k]),
      .valid_o (cell_valid[k+1]),
      .ready_i (cell_ready[k+1]),
      .rem_o   (cell_rem[k+1]),
      .z_o     (cell_z[k+1]),
      .ctrl_o  (cell_ctrl[k+1])
    );
  end

  fsq_back #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cell_valid[ITERS]),
    .ready_o (cell_ready[ITERS]),
    .z_i     (cell_z[ITERS]),
    .ctrl_i  (cell_ctrl[ITERS]),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .root_o  (m_axis_tdata)
  );

  // Requests in flight, for checking occupancy of the chain.
  logic [CNTW-1:0] inflight_q, inflight_d;
  logic            in_fire, out_fire;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  always_comb begin
    inflight_d = inflight_q;
    if (in_fire && !out_fire) begin
      inflight_d = inflight_q + CNTW'(1);
    end else if (!in_fire && out_fire) begin
      inflight_d = inflight_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // Every request in flight occupies exactly one stage.
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(inflight_q) == $countones({cell_valid, m_axis_tvalid}))
    else $error("chain occupancy does not match accepted requests");

  // Input back-pressure only when the whole chain is full and stalled.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && (&cell_valid)))
    else $error("input stalled while the chain has room");

  // A held result moves on only when taken.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped without a handshake");

endmodule

// ===== rtl/fsq_norm.sv =====
// ---------------------------------------------------------------------------
// fsq_norm: classify and normalize the radicand
// Flags zero, negative and near-one inputs, then shifts the radicand left
// by an even amount so that its leading one sits in the top two bits below
// the sign.
// ---------------------------------------------------------------------------
module fsq_norm #(
  parameter int unsigned WORD_BITS = fsq_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = fsq_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [WORD_BITS-1:0] radicand_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [WORD_BITS-1:0] rem_o,
  output fsq_pkg::fsq_ctrl_t   ctrl_o
);

  localparam int unsigned MSBW = $clog2(WORD_BITS);
  localparam int unsigned HALF = FRAC_BITS >> 1;
  localparam logic [64:0] ONE_W  = 65'd1 << FRAC_BITS;
  localparam logic [64:0] EPS_W  = 65'd1 << (HALF - 1);
  localparam logic [64:0] ONE_LO = ONE_W - EPS_W;
  localparam logic [64:0] ONE_HI = ONE_W + EPS_W;
  localparam logic [MSBW-1:0] LEAD = MSBW'(WORD_BITS - 2);

  logic                 valid_q;
  logic [WORD_BITS-1:0] rem_q, rem_d;
  fsq_pkg::fsq_ctrl_t   ctrl_q, ctrl_d;

  logic [MSBW-1:0] msb;
  logic [MSBW-1:0] gap;
  logic [MSBW-1:0] shift;
  logic [64:0]     val_w;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    msb = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (radicand_i[i]) begin
        msb = MSBW'(i);
      end
    end
    gap   = LEAD - msb;
    shift = {gap[MSBW-1:1], 1'b0};
    val_w = 65'(radicand_i);
    rem_d = radicand_i << shift;
    ctrl_d.shift_half = fsq_pkg::SHALF_BITS'(gap >> 1);
    if (radicand_i[WORD_BITS-1] || (radicand_i == '0)) begin
      ctrl_d.kind = fsq_pkg::KIND_ZERO;
    end else if ((val_w >= ONE_LO) && (val_w <= ONE_HI)) begin
      ctrl_d.kind = fsq_pkg::KIND_ONE;
    end else begin
      ctrl_d.kind = fsq_pkg::KIND_ROOT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q  <= rem_d;
      ctrl_q <= ctrl_d;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign ctrl_o  = ctrl_q;

endmodule

// ===== rtl/fsq_cell.sv =====
// ---------------------------------------------------------------------------
// fsq_cell: one digit of the restoring square root
// Tries the next root bit against the partial remainder, keeps it when the
// remainder allows, and hands remainder and partial root to the next cell.
// ---------------------------------------------------------------------------
module fsq_cell #(
  parameter int unsigned WORD_BITS = fsq_pkg::WORD_BITS_DEF,
  parameter int unsigned ITERS     = 16,
  parameter int unsigned STEP      = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [WORD_BITS-1:0] rem_i,
  input  logic [WORD_BITS-1:0] z_i,
  input  fsq_pkg::fsq_ctrl_t   ctrl_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [WORD_BITS-1:0] rem_o,
  output logic [WORD_BITS-1:0] z_o,
  output fsq_pkg::fsq_ctrl_t   ctrl_o
);

  // Weight of the root bit decided in this cell.
  localparam logic [WORD_BITS-1:0] M =
    {{(WORD_BITS-1){1'b0}}, 1'b1} << (2 * (ITERS - 1 - STEP));

  logic                 valid_q;
  logic [WORD_BITS-1:0] rem_q, rem_d;
  logic [WORD_BITS-1:0] z_q, z_d;
  fsq_pkg::fsq_ctrl_t   ctrl_q;
  logic [WORD_BITS:0]   trial;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    trial = {1'b0, z_i} + {1'b0, M};
    if ({1'b0, rem_i} >= trial) begin
      rem_d = rem_i - trial[WORD_BITS-1:0];
      z_d   = (z_i >> 1) + M;
    end else begin
      rem_d = rem_i;
      z_d   = z_i >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q  <= rem_d;
      z_q    <= z_d;
      ctrl_q <= ctrl_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign z_o     = z_q;
  assign ctrl_o  = ctrl_q;

endmodule

// ===== rtl/fsq_back.sv =====
// ---------------------------------------------------------------------------
// fsq_back: scale the root back and hold the result
// Undoes the normalizing shift on the integer root, substitutes the fixed
// answers for zero and near-one inputs, and drives the result register.
// ---------------------------------------------------------------------------
module fsq_back #(
  parameter int unsigned WORD_BITS = fsq_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = fsq_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [WORD_BITS-1:0]          z_i,
  input  fsq_pkg::fsq_ctrl_t            ctrl_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [fsq_pkg::ROOT_BITS-1:0] root_o
);

  localparam int unsigned RB   = fsq_pkg::ROOT_BITS;
  localparam int unsigned XW   = (WORD_BITS > RB) ? WORD_BITS : RB;
  localparam int unsigned HALF = FRAC_BITS >> 1;
  localparam logic [fsq_pkg::SHALF_BITS-1:0] HALF_S = fsq_pkg::SHALF_BITS'(HALF);
  localparam logic [64:0] ONE_W = 65'd1 << FRAC_BITS;

  logic          valid_q;
  logic [RB-1:0] root_q, root_d;
  logic [XW-1:0] zx;
  logic [XW-1:0] shifted;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    zx = XW'(z_i);
    if (ctrl_i.shift_half >= HALF_S) begin
      shifted = zx >> (ctrl_i.shift_half - HALF_S);
    end else begin
      shifted = zx << (HALF_S - ctrl_i.shift_half);
    end
    case (ctrl_i.kind)
      fsq_pkg::KIND_ROOT: root_d = shifted[RB-1:0];
      fsq_pkg::KIND_ONE:  root_d = ONE_W[RB-1:0];
      default:            root_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      root_q <= root_d;
    end
  end

  assign valid_o = valid_q;
  assign root_o  = root_q;

endmodule

// ===== verif/fixed_sqrt_16_16_top_tb.sv =====
// ---------------------------------------------------------------------------
// fixed_sqrt_16_16_top_tb: stream test of the 16.16 fixed-point square root
// Sends directed and random radicands through s_axis. Each accepted
// radicand gets its root computed by a digit-by-digit predictor, and every
// root taken from m_axis is compared in order. Both sides idle at random.
// The receiver also holds off for a long stretch so that the chain fills
// up and stalls its input.
// ---------------------------------------------------------------------------
module fixed_sqrt_16_16_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RAD_BITS    = fsq_pkg::WORD_BITS_DEF;
  localparam int unsigned ROOT_W      = fsq_pkg::ROOT_BITS;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned SETTLE      = 40;
  localparam int unsigned LIMIT       = 200000;

  typedef logic [RAD_BITS-1:0] radicand_t;
  typedef logic [ROOT_W-1:0]   root_t;

  typedef struct {
    radicand_t radicand;
    root_t     root;
  } root_entry_t;

  class root_scoreboard;
    localparam int unsigned FIX_ONE  = 1 << fsq_pkg::FRAC_BITS_DEF;
    localparam int unsigned NEAR_ONE = 1 << (fsq_pkg::FRAC_BITS_DEF / 2 - 1);
    localparam int          LEAD     = fsq_pkg::WORD_BITS_DEF - 2;
    localparam int          HALF     = fsq_pkg::FRAC_BITS_DEF / 2;

    root_entry_t expected_roots[$];
    int          mismatch_count = 0;

    function root_t sqrt_fixed(radicand_t radicand);
      longint unsigned rem;
      longint unsigned z;
      longint unsigned m;
      longint unsigned trial;
      int              msb;
      int              shift;
      int              back;
      if (radicand == '0 || radicand[RAD_BITS-1]) return '0;
      if (radicand >= FIX_ONE - NEAR_ONE && radicand <= FIX_ONE + NEAR_ONE)
        return root_t'(FIX_ONE);
      msb = 0;
      for (int i = 0; i < RAD_BITS; i++) if (radicand[i]) msb = i;
      // Normalize by an even shift so the lead sits in bit 30 or 29.
      shift = (LEAD - msb) & ~1;
      rem   = 64'(radicand) << shift;
      back  = (shift >> 1) - HALF;
      z     = 0;
      m     = 64'd1 << ((msb + shift) & ~1);
      while (m != 0) begin
        trial = z + m;
        z = z >> 1;
        if (rem >= trial) begin
          rem = rem - trial;
          z   = z + m;
        end
        m = m >> 2;
      end
      if (back >= 0) z = z >> back;
      else z = z << (-back);
      return z[ROOT_W-1:0];
    endfunction

    function void note_radicand(radicand_t radicand);
      root_entry_t e;
      e.radicand = radicand;
      e.root     = sqrt_fixed(radicand);
      expected_roots.push_back(e);
    endfunction

    function void check_root(root_t actual);
      root_entry_t e;
      if (expected_roots.size() == 0) begin
        $display("%0t: unexpected root %h with no radicand pending", $time, actual);
        mismatch_count++;
        return;
      end
      e = expected_roots.pop_front();
      if (actual !== e.root) begin
        $display("%0t: root mismatch for radicand %h: expected %h, actual %h",
                 $time, e.radicand, e.root, actual);
        mismatch_count++;
      end
    endfunction

    function int pending();
      return expected_roots.size();
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      s_axis_tvalid;
  logic      s_axis_tready;
  radicand_t s_axis_tdata;   // radicand
  logic      m_axis_tvalid;
  logic      m_axis_tready;
  root_t     m_axis_tdata;   // root

  root_scoreboard sb = new();
  bit             hold_req   = 1'b0;
  bit             rx_random  = 1'b0;
  int unsigned    cycle_count = 0;

  fixed_sqrt_16_16_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("fixed_sqrt_16_16_top verification failed");
      $finish;
    end
  end

  // Inputs only change at rising edges, so values seen at the falling edge
  // are the ones the next rising edge takes.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_radicand(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_root(m_axis_tdata);
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (rx_random && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Call at a rising edge; returns at the edge that accepts the request.
  task automatic send_radicand(input radicand_t value, input bit gaps);
    bit taken;
    if (gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic wait_roots_done();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic radicand_t random_radicand();
    radicand_t v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom >> $urandom_range(1, 31);
      2: v = 32'h0001_0000 - 160 + $urandom_range(0, 320);
      3: v = $urandom_range(1, 300);
      4: v = $urandom | 32'h8000_0000;
      default: v = $urandom & 32'h7FFF_FFFF;
    endcase
    return v;
  endfunction

  task automatic send_random(input int unsigned count, input bit gaps);
    repeat (count) send_radicand(random_radicand(), gaps);
  endtask

  radicand_t directed[$] = '{
    32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
    32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hC000_0000,
    32'h0001_0000, 32'h0000_FF80, 32'h0001_0080, 32'h0000_FF7F,
    32'h0001_0081, 32'h4000_0000, 32'h3FFF_FFFF, 32'h2000_0000,
    32'h0000_0004, 32'h0000_0100, 32'h0100_0000, 32'h00FF_FFFF,
    32'h1234_5678, 32'h0002_0000, 32'h5555_5555, 32'hAAAA_AAAA
  };

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rx_random = 1'b1;
    foreach (directed[i]) send_radicand(directed[i], 1'b1);
    wait_roots_done();

    // Hold the receiver off and keep offering so the chain fills up.
    hold_req = 1'b1;
    send_random(40, 1'b0);
    wait_roots_done();

    send_random(410, 1'b1);
    wait_roots_done();

    // Final stretch at full rate on both sides.
    rx_random = 1'b0;
    send_random(100, 1'b0);
    wait_roots_done();

    if (sb.mismatch_count == 0) begin
      $display("fixed_sqrt_16_16_top verification clean");
    end else begin
      $display("fixed_sqrt_16_16_top verification failed");
    end
    $finish;
  end

endmodule
